>>> sv/rc4_pkg.sv
package rc4_pkg;

  localparam int unsigned MAX_KEY_LEN_DEF = 256;
  localparam int unsigned DATA_W          = 8;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_GEN  = 1'b1;

  typedef logic [DATA_W-1:0] data_t;

  typedef struct packed {
    logic  action;
    data_t key_byte;
    logic  key_last;
  } in_item_t;

  typedef struct packed {
    logic  vld;
    data_t keystream_byte;
    logic  key_ready;
  } res_t;

endpackage

>>> sv/rc4_if.sv
interface rc4_in_if;
  logic              valid;
  logic              ready;
  logic              action;
  rc4_pkg::data_t    key_byte;
  logic              key_last;

  modport source (output valid, output action, output key_byte, output key_last,
                  input ready);
  modport sink (input valid, input action, input key_byte, input key_last,
                output ready);
endinterface

interface rc4_out_if;
  logic              valid;
  logic              ready;
  rc4_pkg::data_t    keystream_byte;
  logic              key_ready;

  modport source (output valid, output keystream_byte, output key_ready,
                  input ready);
  modport sink (input valid, input keystream_byte, input key_ready,
                output ready);
endinterface

>>> sv/rc4_core.sv
module rc4_core #(
  parameter int unsigned MAX_KEY_LEN = rc4_pkg::MAX_KEY_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  rc4_pkg::in_item_t  item,
  output logic               idle,
  output rc4_pkg::res_t      res
);

  localparam int unsigned KAW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int unsigned KCW = $clog2(MAX_KEY_LEN + 1);
  localparam int unsigned TBL = 1 << rc4_pkg::DATA_W;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_FILL = 9'b000000010,
    ST_K0   = 9'b000000100,
    ST_K1   = 9'b000001000,
    ST_K2   = 9'b000010000,
    ST_K3   = 9'b000100000,
    ST_G1   = 9'b001000000,
    ST_G2   = 9'b010000000,
    ST_G3   = 9'b100000000
  } state_t;

  state_t             st_r, st_nxt;
  rc4_pkg::data_t     n_r, n_nxt;
  rc4_pkg::data_t     i_r, i_nxt;
  rc4_pkg::data_t     j_r, j_nxt;
  rc4_pkg::data_t     sa_r, sa_nxt;
  rc4_pkg::data_t     sb_r, sb_nxt;
  rc4_pkg::data_t     t_r, t_nxt;
  logic [KAW-1:0]     kp_r, kp_nxt;
  logic [KCW-1:0]     cnt_r, cnt_nxt;
  logic               sched_r, sched_nxt;

  rc4_pkg::data_t     perm_mem [TBL];
  rc4_pkg::data_t     key_mem [MAX_KEY_LEN];
  rc4_pkg::data_t     prd_q;
  rc4_pkg::data_t     kd_q;

  logic               pwe;
  rc4_pkg::data_t     pwa;
  rc4_pkg::data_t     pwd;
  rc4_pkg::data_t     pra;
  logic               kwe;

  logic [KCW-1:0]     kp_inc;
  logic               last_n;
  rc4_pkg::data_t     j_ksa;
  rc4_pkg::data_t     j_gen;
  rc4_pkg::data_t     t_gen;
  rc4_pkg::data_t     ks_out;

  assign kp_inc = KCW'(kp_r) + KCW'(1);
  assign last_n = (n_r == rc4_pkg::data_t'(TBL - 1));
  assign j_ksa  = 8'(j_r + prd_q + kd_q);
  assign j_gen  = 8'(j_r + prd_q);
  assign t_gen  = 8'(sa_r + prd_q);
  assign idle   = (st_r == ST_IDLE);
  assign kwe    = idle && accept && (item.action == rc4_pkg::ACT_LOAD) &&
                  (cnt_r < KCW'(MAX_KEY_LEN));

  always_comb begin
    if (t_r == j_r) begin
      ks_out = sa_r;
    end else if (t_r == i_r) begin
      ks_out = sb_r;
    end else begin
      ks_out = prd_q;
    end
  end

  always_comb begin
    st_nxt    = st_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    sa_nxt    = sa_r;
    sb_nxt    = sb_r;
    t_nxt     = t_r;
    kp_nxt    = kp_r;
    cnt_nxt   = cnt_r;
    sched_nxt = sched_r;
    pwe       = 1'b0;
    pwa       = n_r;
    pwd       = n_r;
    pra       = n_r;
    res       = '0;
    unique case (st_r)
      ST_IDLE: begin
        pra = 8'(i_r + 8'd1);
        if (accept) begin
          if (item.action == rc4_pkg::ACT_LOAD) begin
            if (kwe) begin
              cnt_nxt = KCW'(cnt_r + KCW'(1));
            end
            if (item.key_last) begin
              n_nxt  = '0;
              st_nxt = ST_FILL;
            end
          end else if (sched_r) begin
            st_nxt = ST_G1;
          end else begin
            res.vld = 1'b1;
          end
        end
      end
      ST_FILL: begin
        pwe   = 1'b1;
        n_nxt = 8'(n_r + 8'd1);
        if (last_n) begin
          kp_nxt = '0;
          j_nxt  = '0;
          st_nxt = ST_K0;
        end
      end
      ST_K0: begin
        st_nxt = ST_K1;
      end
      ST_K1: begin
        sa_nxt = prd_q;
        j_nxt  = j_ksa;
        pra    = j_ksa;
        st_nxt = ST_K2;
      end
      ST_K2: begin
        pwe    = 1'b1;
        pwd    = prd_q;
        st_nxt = ST_K3;
      end
      ST_K3: begin
        pwe    = 1'b1;
        pwa    = j_r;
        pwd    = sa_r;
        n_nxt  = 8'(n_r + 8'd1);
        kp_nxt = (kp_inc >= cnt_r) ? '0 : kp_inc[KAW-1:0];
        if (last_n) begin
          i_nxt     = '0;
          j_nxt     = '0;
          cnt_nxt   = '0;
          sched_nxt = 1'b1;
          st_nxt    = ST_IDLE;
        end else begin
          st_nxt = ST_K0;
        end
      end
      ST_G1: begin
        sa_nxt = prd_q;
        i_nxt  = 8'(i_r + 8'd1);
        j_nxt  = j_gen;
        pra    = j_gen;
        st_nxt = ST_G2;
      end
      ST_G2: begin
        pwe    = 1'b1;
        pwa    = i_r;
        pwd    = prd_q;
        sb_nxt = prd_q;
        t_nxt  = t_gen;
        pra    = t_gen;
        st_nxt = ST_G3;
      end
      ST_G3: begin
        pwe                = 1'b1;
        pwa                = j_r;
        pwd                = sa_r;
        res.vld            = 1'b1;
        res.keystream_byte = ks_out;
        res.key_ready      = 1'b1;
        st_nxt             = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      n_r     <= '0;
      i_r     <= '0;
      j_r     <= '0;
      kp_r    <= '0;
      cnt_r   <= '0;
      sched_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      n_r     <= n_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      kp_r    <= kp_nxt;
      cnt_r   <= cnt_nxt;
      sched_r <= sched_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sa_r <= sa_nxt;
    sb_r <= sb_nxt;
    t_r  <= t_nxt;
  end

  always_ff @(posedge clk) begin
    if (pwe) begin
      perm_mem[pwa] <= pwd;
    end
    prd_q <= perm_mem[pra];
  end

  always_ff @(posedge clk) begin
    if (kwe) begin
      key_mem[cnt_r[KAW-1:0]] <= item.key_byte;
    end
    kd_q <= key_mem[kp_r];
  end

endmodule

>>> sv/rc4_keystream_generator.sv
// Generate item: the block steps through G1, G2 and G3, then the result enters the
// output register; no new item is taken until it is back in idle, since the single
// read port of the permutation table takes three steps per item.
// Generate item before any key schedule: result is registered at the accepting edge.
// Load item: the final key byte starts the key schedule (a fill of all 256 table
// entries, then states K0 to K3 per entry), during which no item is accepted.
// Synchronous active-low reset clears control state; the tables are not reset.
module rc4_keystream_generator #(
  parameter int unsigned MAX_KEY_LEN = rc4_pkg::MAX_KEY_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  rc4_in_if.sink            in_ch,
  rc4_out_if.source         out_ch
);

  rc4_pkg::in_item_t  item;
  rc4_pkg::res_t      res;
  logic               idle;
  logic               accept;
  logic               out_free;
  logic               out_vld_r;
  rc4_pkg::data_t     out_byte_r;
  logic               out_rdy_r;

  assign item.action   = in_ch.action;
  assign item.key_byte = in_ch.key_byte;
  assign item.key_last = in_ch.key_last;

  assign out_free    = !out_vld_r || out_ch.ready;
  assign in_ch.ready = idle && out_free;
  assign accept      = in_ch.valid && in_ch.ready;

  rc4_core #(
    .MAX_KEY_LEN (MAX_KEY_LEN)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (item),
    .idle   (idle),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res.vld) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      out_byte_r <= res.keystream_byte;
      out_rdy_r  <= res.key_ready;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.keystream_byte = out_byte_r;
  assign out_ch.key_ready      = out_rdy_r;

`ifndef SYNTHESIS
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld |-> out_free)
    else $error("Result pushed while the output register was occupied.");

  a_unready_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.key_ready) |-> (out_ch.keystream_byte == '0))
    else $error("Keystream byte is nonzero without a scheduled key.");

  a_busy_after_gen: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.action == rc4_pkg::ACT_GEN && !res.vld) |=> !in_ch.ready)
    else $error("Block accepted an item during a keystream step.");
`endif

endmodule

>>> test/tb_rc4_keystream_generator.sv
module tb_rc4_keystream_generator;

  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 1400;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam int unsigned DIR_ROWS    = 18;

  typedef struct packed {
    rc4_pkg::data_t keystream_byte;
    logic           key_ready;
  } ks_t;

  typedef struct packed {
    logic           action;
    rc4_pkg::data_t key_byte;
    logic           key_last;
    int unsigned    reps;
    bit             chk;
    rc4_pkg::data_t exp_byte;
    logic           exp_ready;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{rc4_pkg::ACT_GEN,  8'hFF, 1'b1, 1,   1'b1, 8'h00, 1'b0},
    '{rc4_pkg::ACT_GEN,  8'h00, 1'b0, 1,   1'b1, 8'h00, 1'b0},
    '{rc4_pkg::ACT_GEN,  8'h5A, 1'b0, 1,   1'b1, 8'h00, 1'b0},
    '{rc4_pkg::ACT_LOAD, 8'h00, 1'b1, 1,   1'b0, 8'h00, 1'b0},
    '{rc4_pkg::ACT_GEN,  8'h00, 1'b0, 4,   1'b0, 8'h00, 1'b0},
    '{rc4_pkg::ACT_LOAD, 8'hFF, 1'b1, 1,   1'b0, 8'h00, 1'b0},
    '{rc4_pkg::ACT_GEN,  8'hFF, 1'b1, 4,   1'b0, 8'h00, 1'b0},
    '{rc4_pkg::ACT_LOAD, 8'h4B, 1'b0, 1,   1'b0, 8'h00, 1'b0},
    '{rc4_pkg::ACT_GEN,  8'h00, 1'b0, 2,   1'b0, 8'h00, 1'b0},
    '{rc4_pkg::ACT_LOAD, 8'h65, 1'b0, 1,   1'b0, 8'h00, 1'b0},
    '{rc4_pkg::ACT_LOAD, 8'h79, 1'b1, 1,   1'b0, 8'h00, 1'b0},
    '{rc4_pkg::ACT_GEN,  8'h00, 1'b0, 10,  1'b0, 8'h00, 1'b0},
    '{rc4_pkg::ACT_LOAD, 8'h5A, 1'b0, 256, 1'b0, 8'h00, 1'b0},
    '{rc4_pkg::ACT_LOAD, 8'hC3, 1'b1, 1,   1'b0, 8'h00, 1'b0},
    '{rc4_pkg::ACT_GEN,  8'h00, 1'b0, 3,   1'b0, 8'h00, 1'b0},
    '{rc4_pkg::ACT_LOAD, 8'h3C, 1'b0, 255, 1'b0, 8'h00, 1'b0},
    '{rc4_pkg::ACT_LOAD, 8'h96, 1'b1, 1,   1'b0, 8'h00, 1'b0},
    '{rc4_pkg::ACT_GEN,  8'h00, 1'b0, 3,   1'b0, 8'h00, 1'b0}
  };

  bit   clk = 1'b0;
  logic rst_n;
  logic rx_ready = 1'b0;

  rc4_in_if  in_ch ();
  rc4_out_if out_ch ();

  assign out_ch.ready = rx_ready;

  rc4_keystream_generator #(
    .MAX_KEY_LEN(rc4_pkg::MAX_KEY_LEN_DEF)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  bit [7:0]    s_box [256];
  bit [7:0]    key_bytes [256];
  int unsigned key_len_cnt = 0;
  bit [7:0]    idx_i = 8'h00;
  bit [7:0]    idx_j = 8'h00;
  bit          keyed = 1'b0;
  ks_t         keystream_q [$];
  ks_t         want;

  int unsigned n_items = 0;
  int unsigned n_checked = 0;
  int unsigned n_sched = 0;
  int unsigned n_dropped = 0;
  int unsigned n_err = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_tag = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  function automatic void key_schedule();
    int unsigned len;
    bit [7:0]    j;
    bit [7:0]    t;
    len = (key_len_cnt == 0) ? 1 : key_len_cnt;
    j = 8'h00;
    for (int n = 0; n < 256; n++) s_box[n] = n[7:0];
    for (int n = 0; n < 256; n++) begin
      j = j + s_box[n] + key_bytes[n % len];
      t = s_box[n];
      s_box[n] = s_box[j];
      s_box[j] = t;
    end
    idx_i = 8'h00;
    idx_j = 8'h00;
    key_len_cnt = 0;
    keyed = 1'b1;
    n_sched++;
  endfunction

  function automatic bit next_keystream(input rc4_pkg::in_item_t it, output ks_t res);
    bit [7:0] t;
    res = '0;
    n_items++;
    if (it.action == rc4_pkg::ACT_LOAD) begin
      if (key_len_cnt < rc4_pkg::MAX_KEY_LEN_DEF) begin
        key_bytes[key_len_cnt] = it.key_byte;
        key_len_cnt++;
      end else begin
        n_dropped++;
      end
      if (it.key_last) key_schedule();
      return 1'b0;
    end
    if (!keyed) return 1'b1;
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + s_box[idx_i];
    t = s_box[idx_i];
    s_box[idx_i] = s_box[idx_j];
    s_box[idx_j] = t;
    t = s_box[idx_i] + s_box[idx_j];
    res.keystream_byte = s_box[t];
    res.key_ready = 1'b1;
    return 1'b1;
  endfunction

  task automatic send_item(input rc4_pkg::in_item_t it, input bit chk, input ks_t typed_res);
    ks_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= it.action;
    in_ch.key_byte <= it.key_byte;
    in_ch.key_last <= it.key_last;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    if (next_keystream(it, res)) keystream_q.push_back(chk ? typed_res : res);
  endtask

  task automatic send_rand_gen();
    rc4_pkg::in_item_t it;
    it.action   = rc4_pkg::ACT_GEN;
    it.key_byte = 8'($urandom);
    it.key_last = 1'($urandom);
    send_item(it, 1'b0, '0);
  endtask

  task automatic send_key_sequence();
    int unsigned       r;
    int unsigned       len;
    int unsigned       ngen;
    bit                broken;
    rc4_pkg::in_item_t it;
    r = $urandom_range(99);
    if (r < 80) len = $urandom_range(16, 1);
    else if (r < 90) len = $urandom_range(64, 17);
    else if (r < 95) len = $urandom_range(256, 200);
    else len = $urandom_range(280, 257);
    broken = ($urandom_range(99) < 5);
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(99) < 10) send_rand_gen();
      it.action   = rc4_pkg::ACT_LOAD;
      it.key_byte = 8'($urandom);
      it.key_last = (k == len - 1) && !broken;
      send_item(it, 1'b0, '0);
    end
    ngen = ($urandom_range(99) < 88) ? $urandom_range(40, 1) : $urandom_range(300, 256);
    repeat (ngen) send_rand_gen();
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (keystream_q.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (keystream_q.size() == 0) begin
        $error("unexpected result: keystream_byte %02h key_ready %0b",
               out_ch.keystream_byte, out_ch.key_ready);
        n_err++;
      end else begin
        want = keystream_q.pop_front();
        if (out_ch.keystream_byte !== want.keystream_byte) begin
          $error("keystream_byte: expected %02h, got %02h",
                 want.keystream_byte, out_ch.keystream_byte);
          n_err++;
        end
        if (out_ch.key_ready !== want.key_ready) begin
          $error("key_ready: expected %0b, got %0b", want.key_ready, out_ch.key_ready);
          n_err++;
        end
        n_checked++;
      end
    end
    if (hold_tag != hold_seen) begin
      hold_seen <= hold_tag;
      hold_left <= HOLD_CYCLES;
      rx_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rx_ready  <= 1'b0;
    end else begin
      rx_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** rc4_keystream_generator: FAILED **");
      $finish;
    end
  end

  initial begin
    rc4_pkg::in_item_t it;
    int unsigned       base;
    in_ch.valid    = 1'b0;
    in_ch.action   = rc4_pkg::ACT_LOAD;
    in_ch.key_byte = '0;
    in_ch.key_last = 1'b0;
    rst_n          = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct  = 20;
    stall_pct = 20;
    for (int r = 0; r < DIR_ROWS; r++) begin
      it.action   = DIR_TAB[r].action;
      it.key_byte = DIR_TAB[r].key_byte;
      it.key_last = DIR_TAB[r].key_last;
      repeat (DIR_TAB[r].reps) begin
        send_item(it, DIR_TAB[r].chk,
                  ks_t'{DIR_TAB[r].exp_byte, DIR_TAB[r].exp_ready});
      end
    end
    drain_results();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 74;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 74;
        end
        default: begin
          idle_pct  = 9;
          stall_pct = 9;
        end
      endcase
      // In the first phase the output side holds off while a run of 64 generate items is sent.
      if (p == 0) begin
        hold_tag <= hold_tag + 1;
        repeat (64) send_rand_gen();
      end
      base = n_items;
      while (n_items < base + PHASE_ITEMS) send_key_sequence();
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d keystream bytes from %0d items across %0d key schedules,",
             n_checked, n_items, n_sched);
    $display("with %0d over-long key bytes dropped, under four idling patterns.", n_dropped);
    if (n_err == 0 && keystream_q.size() == 0) begin
      $display("** rc4_keystream_generator: PASSED **");
    end else begin
      $display("** rc4_keystream_generator: FAILED **");
    end
    $finish;
  end

endmodule
